/* rtl/pfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pkg
// shared constants, types and key square lookups for the playfair digraph
// cipher
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int unsigned SQ_DIM = 5;
  localparam int unsigned POS_W  = $clog2(SQ_DIM);
  localparam logic [7:0]  PAD_CHAR = 8'h78;  // 'x'

  localparam logic [7:0] KEY_SQUARE [SQ_DIM][SQ_DIM] = '{
    '{8'h6d, 8'h6f, 8'h6e, 8'h61, 8'h72},  // m o n a r
    '{8'h63, 8'h68, 8'h79, 8'h62, 8'h64},  // c h y b d
    '{8'h65, 8'h66, 8'h67, 8'h69, 8'h6b},  // e f g i k
    '{8'h6c, 8'h70, 8'h71, 8'h73, 8'h74},  // l p q s t
    '{8'h75, 8'h76, 8'h77, 8'h78, 8'h7a}   // u v w x z
  };

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } pos_t;

  // one digraph to encipher, emitted once or (padded repeat at end) twice
  typedef struct packed {
    pos_t a;
    pos_t b;
    logic two_pairs;
    logic eom;
  } job_t;

  // letters outside the square sit at row 0, column 0
  function automatic pos_t locate(input logic [7:0] c);
    pos_t p;
    p = '0;
    for (int r = 0; r < SQ_DIM; r++) begin
      for (int k = 0; k < SQ_DIM; k++) begin
        if (KEY_SQUARE[r][k] == c) begin
          p.row = POS_W'(r);
          p.col = POS_W'(k);
        end
      end
    end
    return p;
  endfunction

  // one step along a row or column with wrap, +1 or -1
  function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] v,
                                                input logic dec);
    logic [POS_W-1:0] r;
    if (dec) begin
      r = (v == '0) ? POS_W'(SQ_DIM - 1) : v - POS_W'(1);
    end else begin
      r = (v == POS_W'(SQ_DIM - 1)) ? '0 : v + POS_W'(1);
    end
    return r;
  endfunction

endpackage

/* rtl/pfc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_if
// valid/ready channels of the playfair digraph cipher
// ----------------------------------------------------------------------------
interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_message;
  modport source (output valid, char_in, end_of_message, input ready);
  modport sink   (input valid, char_in, end_of_message, output ready);
endinterface

interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       run_end;
  logic       message_end;
  modport source (output valid, char_out, run_end, message_end, input ready);
  modport sink   (input valid, char_out, run_end, message_end, output ready);
endinterface

interface pfc_cfg_if;
  logic valid;
  logic ready;
  logic decrypt_mode;
  modport source (output valid, decrypt_mode, input ready);
  modport sink   (input valid, decrypt_mode, output ready);
endinterface

/* rtl/pfc_pair_gen.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_pair_gen
// pairs incoming letters, holds the pending letter and registers one digraph
// job with its key square positions
// ----------------------------------------------------------------------------
module pfc_pair_gen (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     char_in,
  input  logic           end_of_message,
  output logic           job_valid,
  output pfc_pkg::job_t  job,
  input  logic           job_done
);
  import pfc_pkg::*;

  logic       pending_valid;
  logic [7:0] pending_char;
  logic       accept;
  logic       make_job;
  logic       same;
  logic [7:0] second;

  assign in_ready = !job_valid || job_done;
  assign accept   = in_valid && in_ready;
  assign same     = (pending_char == char_in);
  assign make_job = pending_valid || end_of_message;
  // partner letter of the pair
  assign second   = (pending_valid && !same) ? char_in : PAD_CHAR;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      pending_char  <= '0;
      job_valid     <= 1'b0;
    end else begin
      if (accept && make_job) begin
        job_valid <= 1'b1;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end
      if (accept) begin
        if (end_of_message || (pending_valid && !same)) begin
          pending_valid <= 1'b0;
          pending_char  <= '0;
        end else begin
          pending_valid <= 1'b1;
          pending_char  <= char_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && make_job) begin
      job.a         <= locate(pending_valid ? pending_char : char_in);
      job.b         <= locate(second);
      job.two_pairs <= pending_valid && same && end_of_message;
      job.eom       <= end_of_message;
    end
  end

endmodule

/* rtl/pfc_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_cipher
// playfair rule on one digraph: row shift, column shift or column swap
// ----------------------------------------------------------------------------
module pfc_cipher (
  input  pfc_pkg::pos_t a,
  input  pfc_pkg::pos_t b,
  input  logic          decrypt_mode,
  output logic [7:0]    letter_a,
  output logic [7:0]    letter_b
);
  import pfc_pkg::*;

  pos_t na;
  pos_t nb;

  always_comb begin
    na = a;
    nb = b;
    if (a.row == b.row) begin
      na.col = step_pos(a.col, decrypt_mode);
      nb.col = step_pos(b.col, decrypt_mode);
    end else if (a.col == b.col) begin
      na.row = step_pos(a.row, decrypt_mode);
      nb.row = step_pos(b.row, decrypt_mode);
    end else begin
      na.col = b.col;
      nb.col = a.col;
    end
  end

  assign letter_a = KEY_SQUARE[na.row][na.col];
  assign letter_b = KEY_SQUARE[nb.row][nb.col];

endmodule

/* rtl/pfc_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_emit
// walks job letters to the output register, one beat per cycle unless stalled
// ----------------------------------------------------------------------------
module pfc_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  pfc_pkg::job_t job,
  input  logic [7:0]    letter_a,
  input  logic [7:0]    letter_b,
  output logic          job_done,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    char_out,
  output logic          run_end,
  output logic          message_end
);
  import pfc_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       last;

  assign load     = job_valid && (!out_valid || out_ready);
  assign last     = job.two_pairs ? (idx == 2'd3) : (idx == 2'd1);
  assign job_done = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_out    <= idx[0] ? letter_b : letter_a;
      run_end     <= last;
      message_end <= last && job.eom;
    end
  end

endmodule

/* rtl/playfair_digraph_cipher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_cipher
// playfair digraph cipher over a fixed 5x5 key square, letter stream in and out
// ----------------------------------------------------------------------------
// usage
//   letters: one ascii byte per beat, end_of_message flags the last letter
//   ciphers: one enciphered byte per beat; run_end marks the last letter a
//     given input beat caused, message_end the last letter of the message
//   cfg: single write of decrypt_mode, always ready; write only while idle
// timing
//   an input beat that completes a pair is registered as a job, and its first
//   output letter then moves from the job into the output register; the
//   output register drains one letter per cycle while the output is not
//   stalled, so a beat yields two letters (one pair) or four letters
//   (repeated letter at end of message, two pairs); a beat that only parks a
//   letter yields none. the single output letter register sets the rate
//   while a job is held, a new letter is taken in the cycle the last letter
//   of the current job moves into the output register
// reset
//   clears the pending letter, the job slot, the output register and selects
//   encryption
// stall
//   a stalled output holds its beat; the job slot fills and then letters
//   back-pressures
// ----------------------------------------------------------------------------
module playfair_digraph_cipher (
  input  logic      clk,
  input  logic      rst,
  pfc_in_if.sink    letters,
  pfc_out_if.source ciphers,
  pfc_cfg_if.sink   cfg
);
  import pfc_pkg::*;

  logic       decrypt_mode;
  logic       job_valid;
  logic       job_done;
  job_t       job;
  logic [7:0] letter_a;
  logic [7:0] letter_b;

  // config register, always ready; sender writes it only while idle, unenforced
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode <= 1'b0;
    end else if (cfg.valid) begin
      decrypt_mode <= cfg.decrypt_mode;
    end
  end

  // pending letter and registered digraph positions
  pfc_pair_gen u_pair_gen (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (letters.valid),
    .in_ready       (letters.ready),
    .char_in        (letters.char_in),
    .end_of_message (letters.end_of_message),
    .job_valid      (job_valid),
    .job            (job),
    .job_done       (job_done)
  );

  // key square rule on the held digraph
  pfc_cipher u_cipher (
    .a            (job.a),
    .b            (job.b),
    .decrypt_mode (decrypt_mode),
    .letter_a     (letter_a),
    .letter_b     (letter_b)
  );

  // letter sequencing into the output register
  pfc_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (job),
    .letter_a    (letter_a),
    .letter_b    (letter_b),
    .job_done    (job_done),
    .out_valid   (ciphers.valid),
    .out_ready   (ciphers.ready),
    .char_out    (ciphers.char_out),
    .run_end     (ciphers.run_end),
    .message_end (ciphers.message_end)
  );

endmodule

/* rtl/pfc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfc_checker
// port level checks of the playfair digraph cipher
// ----------------------------------------------------------------------------
module pfc_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic run_end,
  input logic message_end
);

  // a stalled beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // end of message is always the end of a run
  a_msg_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_end |-> run_end)
    else $error("message_end without run_end");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // reset empties the job slot, so letters are taken at once
  a_rst_in: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (letters.ready),
  .out_valid   (ciphers.valid),
  .out_ready   (ciphers.ready),
  .run_end     (ciphers.run_end),
  .message_end (ciphers.message_end)
);
